// ===== hw/rtl/bcdas_pkg.sv =====
// ============================================================================
// bcdas_pkg - shared types and helpers for the BCD sign-magnitude add/sub
// Digit-lane record, operand control record, result record, stream widths
// and the decimal digit correction functions.
// ============================================================================
package bcdas_pkg;

    // Field widths
    localparam int MAG_W      = 64;
    localparam int NIB_W      = 4;
    localparam int MAX_DIGITS = MAG_W / NIB_W;

    // Stream layout, input: a_digits, a_sign, b_digits, b_sign
    localparam int A_DIG_LSB  = 0;
    localparam int A_SIGN_BIT = A_DIG_LSB + MAG_W;
    localparam int B_DIG_LSB  = A_SIGN_BIT + 1;
    localparam int B_SIGN_BIT = B_DIG_LSB + MAG_W;
    localparam int S_FIELD_W  = B_SIGN_BIT + 1;
    localparam int S_TDATA_W  = ((S_FIELD_W + 7) / 8) * 8;

    // Stream layout, output: result_digits, result_sign, overflow
    localparam int R_SIGN_BIT = MAG_W;
    localparam int R_OVF_BIT  = MAG_W + 1;
    localparam int M_FIELD_W  = MAG_W + 2;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // Command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    // Decimal constants
    localparam int DEC_MAX  = 9;
    localparam int DEC_BASE = 10;

    // Per-digit lane findings: raw column sum and both raw differences,
    // each with its carry/borrow generate and propagate bits
    typedef struct packed {
        logic [4:0]        add_sum;
        logic              add_g;
        logic              add_p;
        logic signed [4:0] ab_diff;
        logic              ab_g;
        logic              ab_p;
        logic signed [4:0] ba_diff;
        logic              ba_g;
        logic              ba_p;
    } lane_t;

    // Operand-wide control found in the first stage
    typedef struct packed {
        logic like;      // effective signs equal
        logic a_gt;      // |a| > |b|
        logic a_eq;      // |a| == |b|
        logic a_sign;
        logic b_sign;    // b sign after the command is applied
    } op_t;

    typedef struct packed {
        logic             overflow;
        logic             sign;
        logic [MAG_W-1:0] digits;
    } res_t;

    // Column sum plus incoming carry, brought back into one digit
    function automatic logic [NIB_W-1:0] add_fix(input logic [4:0] s0, input logic cin);
        logic [4:0] t;
        t = s0 + {4'b0, cin};
        if (t > 5'(DEC_MAX)) begin
            t = t - 5'(DEC_BASE);
        end
        return t[NIB_W-1:0];
    endfunction

    // Column difference minus incoming borrow, brought back into one digit
    function automatic logic [NIB_W-1:0] sub_fix(input logic signed [4:0] d0,
                                                 input logic bin);
        logic signed [5:0] t;
        t = {d0[4], d0} - $signed({5'b0, bin});
        if (t < 0) begin
            t = t + $signed(6'(DEC_BASE));
        end
        return t[NIB_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/bcd_sign_magnitude_add_sub_unit.sv =====
// ============================================================================
// bcd_sign_magnitude_add_sub_unit - decimal sign-magnitude adder/subtractor
// Packed BCD operands with sign flags; add or subtract per request, with
// digit lanes side by side and a merging carry/borrow network.
//
//   channel | ports        | tdata fields (lsb up)                  | tuser
//   --------+--------------+----------------------------------------+--------
//   input   | s_tvalid/rdy | a_digits, a_sign, b_digits, b_sign     | command
//   output  | m_tvalid/rdy | result_digits, result_sign, overflow   | -
//
// One request per cycle sustained while the output is not stalled; the lane
// stage registers, then the carry/borrow network feeds the output register.
// aresetn (synchronous, active low) clears both stage valid flags.
// A stalled output holds its data; the pipeline keeps filling until both
// stages are full, then s_tready drops.
// ============================================================================
module bcd_sign_magnitude_add_sub_unit #(
    parameter int DIGITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_digits[63:0], a_sign[64], b_digits[128:65], b_sign[129], zero pad
    input  logic [bcdas_pkg::S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_digits[63:0], result_sign[64], overflow[65], zero pad
    output logic [bcdas_pkg::M_TDATA_W-1:0] m_tdata
);
    import bcdas_pkg::*;

    logic [MAG_W-1:0]       a_mag;
    logic [MAG_W-1:0]       b_mag;
    lane_t                  lane_next   [DIGITS];
    lane_t                  s1_lane_reg [DIGITS];
    op_t                    op_next;
    op_t                    s1_op_reg;
    logic                   s1_valid_reg;
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;
    res_t                   res;
    logic                   s1_en;
    logic                   s2_en;

    // Handshake: each stage advances when its successor has room
    assign s2_en    = !m_valid_reg || m_tready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;

    // Digits in use; upper nibbles ignored
    always_comb begin
        a_mag = '0;
        b_mag = '0;
        for (int i = 0; i < DIGITS; i++) begin
            a_mag[i*NIB_W +: NIB_W] = s_tdata[A_DIG_LSB + i*NIB_W +: NIB_W];
            b_mag[i*NIB_W +: NIB_W] = s_tdata[B_DIG_LSB + i*NIB_W +: NIB_W];
        end
    end

    // Digit lanes
    for (genvar g = 0; g < DIGITS; g++) begin : g_lane
        bcdas_lane u_lane (
            .a_nib (a_mag[g*NIB_W +: NIB_W]),
            .b_nib (b_mag[g*NIB_W +: NIB_W]),
            .lane  (lane_next[g])
        );
    end

    // Operand-wide control: effective signs and magnitude compare
    always_comb begin
        op_next.a_sign = s_tdata[A_SIGN_BIT];
        op_next.b_sign = s_tdata[B_SIGN_BIT] ^ (s_tuser[0] == CMD_SUB);
        op_next.like   = op_next.a_sign == op_next.b_sign;
        op_next.a_gt   = a_mag > b_mag;
        op_next.a_eq   = a_mag == b_mag;
    end

    // Lane stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en && s_tvalid) begin
            s1_lane_reg <= lane_next;
            s1_op_reg   <= op_next;
        end
    end

    // Carry/borrow network and select
    bcdas_merge #(
        .DIGITS (DIGITS)
    ) u_merge (
        .lanes (s1_lane_reg),
        .op    (s1_op_reg),
        .res   (res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_en) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en && s1_valid_reg) begin
            m_data_reg <= {(M_TDATA_W - M_FIELD_W)'(0), res.overflow, res.sign, res.digits};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/bcdas_lane.sv =====
// ============================================================================
// bcdas_lane - one decimal digit lane
// Forms the raw column sum and both column differences of one digit pair,
// with generate/propagate terms for the carry and borrow networks.
// ============================================================================
module bcdas_lane (
    input  logic [bcdas_pkg::NIB_W-1:0] a_nib,
    input  logic [bcdas_pkg::NIB_W-1:0] b_nib,
    output bcdas_pkg::lane_t            lane
);
    import bcdas_pkg::*;

    logic [4:0]        sum;
    logic signed [4:0] dab;
    logic signed [4:0] dba;

    // Raw column arithmetic
    assign sum = {1'b0, a_nib} + {1'b0, b_nib};
    assign dab = $signed({1'b0, a_nib}) - $signed({1'b0, b_nib});
    assign dba = $signed({1'b0, b_nib}) - $signed({1'b0, a_nib});

    // Generate: column alone carries/borrows; propagate: only with carry-in
    always_comb begin
        lane.add_sum = sum;
        lane.add_g   = sum > 5'(DEC_MAX);
        lane.add_p   = sum == 5'(DEC_MAX);
        lane.ab_diff = dab;
        lane.ab_g    = dab[4];
        lane.ab_p    = dab == 5'sd0;
        lane.ba_diff = dba;
        lane.ba_g    = dba[4];
        lane.ba_p    = dba == 5'sd0;
    end

endmodule

// ===== hw/rtl/bcdas_merge.sv =====
// ============================================================================
// bcdas_merge - carry/borrow network and result select
// Resolves the decimal carries and borrows across all lanes with one
// binary add each, corrects each digit and picks sum, difference or zero.
// ============================================================================
module bcdas_merge #(
    parameter int DIGITS = 16
) (
    input  bcdas_pkg::lane_t lanes [DIGITS],
    input  bcdas_pkg::op_t   op,
    output bcdas_pkg::res_t  res
);
    import bcdas_pkg::*;

    logic [DIGITS-1:0] add_g;
    logic [DIGITS-1:0] add_gp;
    logic [DIGITS-1:0] sub_g;
    logic [DIGITS-1:0] sub_gp;
    logic [DIGITS:0]   add_t;
    logic [DIGITS:0]   sub_t;
    logic [DIGITS:0]   add_cin;
    logic [DIGITS:0]   sub_bin;
    logic [MAG_W-1:0]  add_dig;
    logic [MAG_W-1:0]  sub_dig;
    logic              ovf;

    // Gather generate/propagate; the subtract side follows the larger operand
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            add_g[i]  = lanes[i].add_g;
            add_gp[i] = lanes[i].add_g | lanes[i].add_p;
            sub_g[i]  = op.a_gt ? lanes[i].ab_g : lanes[i].ba_g;
            sub_gp[i] = op.a_gt ? (lanes[i].ab_g | lanes[i].ab_p)
                                : (lanes[i].ba_g | lanes[i].ba_p);
        end
    end

    // Carry into each lane: the internal carries of g + (g|p)
    assign add_t   = {1'b0, add_g} + {1'b0, add_gp};
    assign sub_t   = {1'b0, sub_g} + {1'b0, sub_gp};
    assign add_cin = add_t ^ {1'b0, add_g} ^ {1'b0, add_gp};
    assign sub_bin = sub_t ^ {1'b0, sub_g} ^ {1'b0, sub_gp};

    // Per-lane digit correction; nibbles above the digit count stay zero
    always_comb begin
        add_dig = '0;
        sub_dig = '0;
        for (int i = 0; i < DIGITS; i++) begin
            add_dig[i*NIB_W +: NIB_W] = add_fix(lanes[i].add_sum, add_cin[i]);
            sub_dig[i*NIB_W +: NIB_W] = sub_fix(op.a_gt ? lanes[i].ab_diff
                                                        : lanes[i].ba_diff,
                                                sub_bin[i]);
        end
    end

    assign ovf = op.like & add_cin[DIGITS];

    // Result select
    always_comb begin
        res.overflow = 1'b0;
        res.sign     = 1'b1;
        res.digits   = '0;
        if (op.like) begin
            if (ovf) begin
                res.overflow = 1'b1;
            end else begin
                res.sign   = op.a_sign;
                res.digits = add_dig;
            end
        end else if (!op.a_eq) begin
            res.sign   = op.a_gt ? op.a_sign : op.b_sign;
            res.digits = sub_dig;
        end
    end

endmodule

// ===== hw/rtl/bcdas_checker.sv =====
// ============================================================================
// bcdas_checker - port-level checks for the BCD add/sub unit
// Watches the top-level ports only; attached by bind.
// ============================================================================
module bcdas_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bcdas_pkg::M_TDATA_W-1:0] m_tdata
);
    import bcdas_pkg::*;

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Overflow result is zero digits with sign flag set
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[R_OVF_BIT] |->
            m_tdata[MAG_W-1:0] == '0 && m_tdata[R_SIGN_BIT])
        else $error("overflow result not zero");

    // Accepted request reaches the output after the lane stage when the sink is ready
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result missing after request");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELD_W] == '0)
        else $error("output padding not zero");

endmodule

bind bcd_sign_magnitude_add_sub_unit bcdas_checker u_bcdas_checker (.*);
